### rtl/core/rclm_pkg.sv
// Shared types, codes and constants of the rolling counter loss monitor.
`default_nettype none

package rclm_pkg;

    localparam int COUNTER_BITS_DEF = 4;
    localparam int FIELD_CNT_W = 4;
    localparam int LOSS_W = 17;
    localparam logic [LOSS_W-1:0] LOSS_SCALE = 17'd100000;

    localparam logic [2:0] WATCHED_BUS_RST = 3'd1;
    localparam logic [28:0] WATCHED_ID_RST = 29'h249;
    localparam logic [31:0] INTERVAL_RST = 32'd5000000;

    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        KIND_FIRST = 3'd0,
        KIND_SEQ = 3'd1,
        KIND_REPEAT = 3'd2,
        KIND_JUMP = 3'd3,
        KIND_WINDOW = 3'd4,
        KIND_TOTAL = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        CFG_WATCHED_BUS = 2'd0,
        CFG_WATCHED_ID = 2'd1,
        CFG_INTERVAL = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic        operation;
        logic [2:0]  bus_number;
        logic [28:0] frame_identifier;
        logic [3:0]  data_length;
        logic [7:0]  second_data_byte;
        logic [63:0] now_us;
    } t_in;

    typedef struct packed {
        logic [2:0]        result_kind;
        logic [3:0]        counter_value;
        logic [3:0]        previous_counter;
        logic [3:0]        skipped_values;
        logic signed [31:0] gap_us;
        logic [63:0]       report_received;
        logic [63:0]       report_jumps;
        logic [63:0]       report_missed;
        logic [16:0]       report_loss_millipercent;
        logic              last_of_run;
    } t_out;

    typedef struct packed {
        logic capture;
        logic eval;
        logic div_start;
        logic sel_total;
        logic load_report;
        logic clear_window;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic due;
        logic div_done;
    } t_sts;

endpackage

`default_nettype wire

### rtl/core/rolling_counter_loss_monitor_top.sv
// Top level of the rolling counter loss monitor.
//
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_ready     i_in_data (t_in)
// result    out        o_out_valid / i_out_ready   o_out_data (t_out)
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One item is processed at a time: accept, evaluate (S_EVAL, then S_CHECK), then up to three results.
// Each report runs through the shared divider unit: its operands are loaded, the product is formed
// in D_MUL_LO, D_MUL_HI and D_SUM, then 17 quotient steps follow.
// Reset is synchronous and active low; no clearing pass is needed after it.
// A stalled result holds the block; configuration writes are always accepted.
`default_nettype none

module rolling_counter_loss_monitor_top #(
    parameter int COUNTER_BITS = rclm_pkg::COUNTER_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire rclm_pkg::t_in      i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output rclm_pkg::t_out          o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire rclm_pkg::t_cfg_idx i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);
    import rclm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    rclm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rclm_datapath #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_data  (o_out_data)
    );

    a_busy_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input accepted while a result is pending");

    a_total_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.result_kind == KIND_TOTAL) |-> o_out_data.last_of_run)
        else $error("total report not marked as last result");

    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.last_of_run) |=> o_in_ready)
        else $error("block not ready after the last result of an item");

endmodule

`default_nettype wire

### rtl/core/rclm_div.sv
// Multicycle unit that computes floor(100000 * missed / divisor) for one report.
`default_nettype none

module rclm_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [63:0]                 i_missed,
    input  wire logic [63:0]                 i_divisor,
    output logic                             o_done,
    output logic [rclm_pkg::LOSS_W-1:0]      o_quotient
);
    import rclm_pkg::*;

    localparam int PROD_W = 64 + LOSS_W;
    localparam int PART_W = 32 + LOSS_W;
    localparam int CNT_W = $clog2(LOSS_W + 1);

    typedef enum logic [4:0] {
        D_IDLE   = 5'b00001,
        D_MUL_LO = 5'b00010,
        D_MUL_HI = 5'b00100,
        D_SUM    = 5'b01000,
        D_ITER   = 5'b10000
    } t_phase;

    t_phase r_phase;
    logic [CNT_W-1:0] r_cnt;
    logic r_done;
    logic [63:0] r_m;
    logic [63:0] r_d;
    logic [PART_W-1:0] r_p0;
    logic [PART_W-1:0] r_p1;
    logic [63:0] r_rem;
    logic [LOSS_W-1:0] r_low;

    logic [PROD_W-1:0] w_prod;
    logic [64:0] w_trial;
    logic [64:0] w_diff;
    logic w_take;

    assign w_prod = {r_p1, 32'b0} + PROD_W'(r_p0);
    assign w_trial = {r_rem, r_low[LOSS_W-1]};
    assign w_take = w_trial >= {1'b0, r_d};
    assign w_diff = w_trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= D_IDLE;
            r_cnt <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                D_IDLE: begin
                    if (i_start) begin
                        r_phase <= D_MUL_LO;
                    end
                end
                D_MUL_LO: r_phase <= D_MUL_HI;
                D_MUL_HI: r_phase <= D_SUM;
                D_SUM: begin
                    r_phase <= D_ITER;
                    r_cnt <= CNT_W'(LOSS_W);
                end
                D_ITER: begin
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_phase <= D_IDLE;
                        r_done <= 1'b1;
                    end
                end
                default: r_phase <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == D_IDLE && i_start) begin
            r_m <= i_missed;
            r_d <= i_divisor;
        end
        if (r_phase == D_MUL_LO) begin
            r_p0 <= PART_W'(r_m[31:0]) * PART_W'(LOSS_SCALE);
        end
        if (r_phase == D_MUL_HI) begin
            r_p1 <= PART_W'(r_m[63:32]) * PART_W'(LOSS_SCALE);
        end
        if (r_phase == D_SUM) begin
            r_rem <= w_prod[PROD_W-1:LOSS_W];
            r_low <= w_prod[LOSS_W-1:0];
        end
        if (r_phase == D_ITER) begin
            r_rem <= w_take ? w_diff[63:0] : w_trial[63:0];
            r_low <= {r_low[LOSS_W-2:0], w_take};
        end
    end

    assign o_done = r_done;
    assign o_quotient = r_low;

endmodule

`default_nettype wire

### rtl/core/rclm_datapath.sv
// Datapath: configuration, sequence state, statistics counters and the result register.
`default_nettype none

module rclm_datapath #(
    parameter int COUNTER_BITS = rclm_pkg::COUNTER_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    input  wire rclm_pkg::t_cfg_idx i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire rclm_pkg::t_in      i_in_data,
    input  wire rclm_pkg::t_cmd     i_cmd,
    output rclm_pkg::t_sts          o_sts,
    output rclm_pkg::t_out          o_out_data
);
    import rclm_pkg::*;

    localparam int EXT_W = COUNTER_BITS + FIELD_CNT_W;

    logic [2:0] r_watched_bus;
    logic [28:0] r_watched_id;
    logic [31:0] r_interval;

    t_in r_in;
    t_out r_res;

    logic r_has_prev;
    logic [COUNTER_BITS-1:0] r_last_counter;
    logic [31:0] r_last_stamp;
    logic [31:0] r_win_rx;
    logic [31:0] r_win_jumps;
    logic [31:0] r_win_missed;
    logic [63:0] r_tot_rx;
    logic [63:0] r_tot_jumps;
    logic [63:0] r_tot_missed;
    logic [63:0] r_deadline;
    logic r_armed;
    logic r_hit;
    logic r_due;

    logic [63:0] w_next_deadline;
    logic [63:0] w_deadline;
    logic w_due;
    logic w_hit;
    logic [COUNTER_BITS-1:0] w_counter;
    logic [COUNTER_BITS-1:0] w_inc;
    logic [COUNTER_BITS-1:0] w_skip;
    logic w_jump;
    logic [31:0] w_gap;
    logic [EXT_W-1:0] w_cnt_ext;
    logic [EXT_W-1:0] w_prev_ext;
    logic [EXT_W-1:0] w_skip_ext;
    t_out w_evt_row;
    t_out w_rep_row;
    logic [63:0] w_rep_rx;
    logic [63:0] w_rep_jumps;
    logic [63:0] w_rep_m;
    logic [63:0] w_rep_d;
    logic [31:0] w_win_sum;
    logic [LOSS_W-1:0] w_quot;
    logic [LOSS_W-1:0] w_loss;
    logic w_div_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_watched_bus <= WATCHED_BUS_RST;
            r_watched_id <= WATCHED_ID_RST;
            r_interval <= INTERVAL_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WATCHED_BUS: r_watched_bus <= i_cfg_data[2:0];
                CFG_WATCHED_ID: r_watched_id <= i_cfg_data[28:0];
                CFG_INTERVAL: r_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_data;
        end
    end

    assign w_next_deadline = r_in.now_us + 64'(r_interval);
    assign w_deadline = r_armed ? r_deadline : w_next_deadline;
    assign w_due = r_in.now_us >= w_deadline;
    assign w_hit = (r_in.operation == OP_FRAME) && (r_in.bus_number == r_watched_bus)
                   && (r_in.frame_identifier == r_watched_id);
    assign w_counter = (r_in.data_length >= 4'd2) ?
                       r_in.second_data_byte[COUNTER_BITS-1:0] : '0;
    assign w_inc = r_last_counter + COUNTER_BITS'(1);
    assign w_skip = w_counter - r_last_counter - COUNTER_BITS'(1);
    assign w_jump = r_has_prev && (w_counter != r_last_counter) && (w_counter != w_inc);
    assign w_gap = r_in.now_us[31:0] - r_last_stamp;
    assign w_cnt_ext = EXT_W'(w_counter);
    assign w_prev_ext = EXT_W'(r_last_counter);
    assign w_skip_ext = EXT_W'(w_skip);

    always_comb begin
        w_evt_row = '0;
        w_evt_row.counter_value = w_cnt_ext[FIELD_CNT_W-1:0];
        w_evt_row.last_of_run = !w_due;
        if (!r_has_prev) begin
            w_evt_row.result_kind = KIND_FIRST;
        end else begin
            w_evt_row.previous_counter = w_prev_ext[FIELD_CNT_W-1:0];
            w_evt_row.gap_us = w_gap;
            if (w_counter == r_last_counter) begin
                w_evt_row.result_kind = KIND_REPEAT;
            end else if (w_counter == w_inc) begin
                w_evt_row.result_kind = KIND_SEQ;
            end else begin
                w_evt_row.result_kind = KIND_JUMP;
                w_evt_row.skipped_values = w_skip_ext[FIELD_CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_prev <= 1'b0;
            r_last_counter <= '0;
            r_last_stamp <= '0;
            r_win_rx <= '0;
            r_win_jumps <= '0;
            r_win_missed <= '0;
            r_tot_rx <= '0;
            r_tot_jumps <= '0;
            r_tot_missed <= '0;
            r_deadline <= '0;
            r_armed <= 1'b0;
            r_hit <= 1'b0;
            r_due <= 1'b0;
        end else if (i_cmd.eval) begin
            r_armed <= 1'b1;
            r_hit <= w_hit;
            r_due <= w_due;
            if (!r_armed || w_due) begin
                r_deadline <= w_next_deadline;
            end
            if (w_hit) begin
                r_has_prev <= 1'b1;
                r_last_counter <= w_counter;
                r_last_stamp <= r_in.now_us[31:0];
                r_win_rx <= r_win_rx + 32'd1;
                r_tot_rx <= r_tot_rx + 64'd1;
                if (w_jump) begin
                    r_win_jumps <= r_win_jumps + 32'd1;
                    r_tot_jumps <= r_tot_jumps + 64'd1;
                    r_win_missed <= r_win_missed + 32'(w_skip);
                    r_tot_missed <= r_tot_missed + 64'(w_skip);
                end
            end
        end else if (i_cmd.clear_window) begin
            r_win_rx <= '0;
            r_win_jumps <= '0;
            r_win_missed <= '0;
        end
    end

    assign w_win_sum = r_win_rx + r_win_missed;
    assign w_rep_rx = i_cmd.sel_total ? r_tot_rx : 64'(r_win_rx);
    assign w_rep_jumps = i_cmd.sel_total ? r_tot_jumps : 64'(r_win_jumps);
    assign w_rep_m = i_cmd.sel_total ? r_tot_missed : 64'(r_win_missed);
    assign w_rep_d = i_cmd.sel_total ? (r_tot_rx + r_tot_missed) : 64'(w_win_sum);

    rclm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_missed   (w_rep_m),
        .i_divisor  (w_rep_d),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    always_comb begin
        if (w_rep_d == 64'd0) begin
            w_loss = '0;
        end else if (w_rep_m > w_rep_d) begin
            w_loss = LOSS_SCALE;
        end else begin
            w_loss = w_quot;
        end
    end

    always_comb begin
        w_rep_row = '0;
        w_rep_row.result_kind = i_cmd.sel_total ? KIND_TOTAL : KIND_WINDOW;
        w_rep_row.report_received = w_rep_rx;
        w_rep_row.report_jumps = w_rep_jumps;
        w_rep_row.report_missed = w_rep_m;
        w_rep_row.report_loss_millipercent = w_loss;
        w_rep_row.last_of_run = i_cmd.sel_total;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval && w_hit) begin
            r_res <= w_evt_row;
        end else if (i_cmd.load_report) begin
            r_res <= w_rep_row;
        end
    end

    assign o_sts.hit = r_hit;
    assign o_sts.due = r_due;
    assign o_sts.div_done = w_div_done;
    assign o_out_data = r_res;

endmodule

`default_nettype wire

### rtl/core/rclm_ctrl.sv
// Controller state machine that sequences evaluation, divisions and result transactions.
`default_nettype none

module rclm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire rclm_pkg::t_sts i_sts,
    output rclm_pkg::t_cmd      o_cmd
);
    import rclm_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b00000001,
        S_EVAL    = 8'b00000010,
        S_CHECK   = 8'b00000100,
        S_OUT_EVT = 8'b00001000,
        S_DIV_WIN = 8'b00010000,
        S_OUT_WIN = 8'b00100000,
        S_DIV_TOT = 8'b01000000,
        S_OUT_TOT = 8'b10000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic w_out_valid;
    logic w_fire;

    assign w_out_valid = r_state inside {S_OUT_EVT, S_OUT_WIN, S_OUT_TOT};
    assign w_fire = w_out_valid && i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: n_state = S_CHECK;
            S_CHECK: begin
                if (i_sts.hit) begin
                    n_state = S_OUT_EVT;
                end else if (i_sts.due) begin
                    n_state = S_DIV_WIN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT_EVT: begin
                if (w_fire) begin
                    n_state = i_sts.due ? S_DIV_WIN : S_IDLE;
                end
            end
            S_DIV_WIN: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT_WIN;
                end
            end
            S_OUT_WIN: begin
                if (w_fire) begin
                    n_state = S_DIV_TOT;
                end
            end
            S_DIV_TOT: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT_TOT;
                end
            end
            S_OUT_TOT: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        o_cmd.eval = (r_state == S_EVAL);
        o_cmd.div_start = ((r_state == S_CHECK) && !i_sts.hit && i_sts.due)
                          || ((r_state == S_OUT_EVT) && w_fire && i_sts.due)
                          || ((r_state == S_OUT_WIN) && w_fire);
        o_cmd.sel_total = r_state inside {S_OUT_WIN, S_DIV_TOT};
        o_cmd.load_report = (r_state inside {S_DIV_WIN, S_DIV_TOT}) && i_sts.div_done;
        o_cmd.clear_window = (r_state == S_OUT_WIN) && w_fire;
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = w_out_valid;

endmodule

`default_nettype wire

### verif/tb.sv
// Testbench of the rolling counter loss monitor: a directed table, then checked random traffic.
`timescale 1ns / 1ps

module tb;
    import rclm_pkg::*;

    localparam int SETTLE_CYCLES = 64;

    typedef struct {
        bit          is_write;
        t_cfg_idx    reg_idx;
        logic [31:0] reg_val;
        t_in         item;
        bit          pinned;
        t_out        want;
    } t_step;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index = CFG_WATCHED_BUS;
    logic [31:0] i_cfg_data = '0;

    rolling_counter_loss_monitor_top i_dut (.*);

    always #6 i_clk = ~i_clk;

    // Shadow copy of the monitor's registers and counters.
    logic [2:0]  cfg_bus = WATCHED_BUS_RST;
    logic [28:0] cfg_id = WATCHED_ID_RST;
    logic [31:0] cfg_interval = INTERVAL_RST;
    bit          has_prev = 1'b0;
    logic [3:0]  last_ctr = '0;
    logic [31:0] last_stamp = '0;
    logic [31:0] win_rx = '0;
    logic [31:0] win_jumps = '0;
    logic [31:0] win_missed = '0;
    logic [63:0] tot_rx = '0;
    logic [63:0] tot_jumps = '0;
    logic [63:0] tot_missed = '0;
    logic [63:0] deadline = '0;
    bit          armed = 1'b0;

    t_out  events_due[$];
    t_step plan[$];
    int    mismatches = 0;
    int    snd_idle_pct = 0;
    int    rcv_idle_pct = 0;

    task automatic note_mismatch(input string what);
        mismatches++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want) begin
            note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    function automatic logic [16:0] loss_of(input logic [63:0] missed, input logic [63:0] base);
        logic [127:0] q;
        if (base == 64'd0) return '0;
        if (missed > base) return LOSS_SCALE;
        q = ({64'd0, missed} * 128'd100000) / {64'd0, base};
        return q[16:0];
    endfunction

    task automatic predict_events(input t_in d, output int n);
        t_out        ev_frame, ev_win, ev_tot;
        logic [3:0]  ctr, nxt, skip;
        logic [31:0] stamp, wsum;
        logic [63:0] tsum;
        bit          has_frame, has_report;
        ev_frame = '0;
        ev_win = '0;
        ev_tot = '0;
        has_frame = 1'b0;
        has_report = 1'b0;
        if (!armed) begin
            deadline = d.now_us + {32'd0, cfg_interval};
            armed = 1'b1;
        end
        if (d.operation == OP_FRAME && d.bus_number == cfg_bus
                && d.frame_identifier == cfg_id) begin
            ctr = (d.data_length >= 4'd2) ? d.second_data_byte[3:0] : 4'd0;
            stamp = d.now_us[31:0];
            has_frame = 1'b1;
            ev_frame.counter_value = ctr;
            win_rx++;
            tot_rx++;
            if (!has_prev) begin
                ev_frame.result_kind = KIND_FIRST;
            end else begin
                nxt = last_ctr + 4'd1;
                ev_frame.previous_counter = last_ctr;
                ev_frame.gap_us = stamp - last_stamp;
                if (ctr == last_ctr) begin
                    ev_frame.result_kind = KIND_REPEAT;
                end else if (ctr == nxt) begin
                    ev_frame.result_kind = KIND_SEQ;
                end else begin
                    skip = ctr - last_ctr - 4'd1;
                    ev_frame.result_kind = KIND_JUMP;
                    ev_frame.skipped_values = skip;
                    win_jumps++;
                    win_missed += {28'd0, skip};
                    tot_jumps++;
                    tot_missed += {60'd0, skip};
                end
            end
            has_prev = 1'b1;
            last_ctr = ctr;
            last_stamp = stamp;
        end
        if (d.now_us >= deadline) begin
            has_report = 1'b1;
            wsum = win_rx + win_missed;
            tsum = tot_rx + tot_missed;
            ev_win.result_kind = KIND_WINDOW;
            ev_win.report_received = {32'd0, win_rx};
            ev_win.report_jumps = {32'd0, win_jumps};
            ev_win.report_missed = {32'd0, win_missed};
            ev_win.report_loss_millipercent = loss_of({32'd0, win_missed}, {32'd0, wsum});
            ev_tot.result_kind = KIND_TOTAL;
            ev_tot.report_received = tot_rx;
            ev_tot.report_jumps = tot_jumps;
            ev_tot.report_missed = tot_missed;
            ev_tot.report_loss_millipercent = loss_of(tot_missed, tsum);
            win_rx = '0;
            win_jumps = '0;
            win_missed = '0;
            deadline = d.now_us + {32'd0, cfg_interval};
        end
        n = 0;
        if (has_report) ev_tot.last_of_run = 1'b1;
        else if (has_frame) ev_frame.last_of_run = 1'b1;
        if (has_frame) begin
            events_due.push_back(ev_frame);
            n++;
        end
        if (has_report) begin
            events_due.push_back(ev_win);
            events_due.push_back(ev_tot);
            n += 2;
        end
    endtask

    task automatic send_item(input t_in d, output int n);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= d;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_events(d, n);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_WATCHED_BUS: begin
                cfg_bus = val[2:0];
            end
            CFG_WATCHED_ID: begin
                cfg_id = val[28:0];
            end
            CFG_INTERVAL: begin
                cfg_interval = val;
            end
            default: begin
            end
        endcase
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (events_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_step frame_step(input t_op op, input logic [2:0] bus,
                                         input logic [28:0] id, input logic [3:0] dlc,
                                         input logic [7:0] b1, input logic [63:0] now);
        t_step s;
        s = '{reg_idx: CFG_WATCHED_BUS, default: '0};
        s.item.operation = op;
        s.item.bus_number = bus;
        s.item.frame_identifier = id;
        s.item.data_length = dlc;
        s.item.second_data_byte = b1;
        s.item.now_us = now;
        return s;
    endfunction

    function automatic t_step tick_step(input logic [63:0] now);
        return frame_step(OP_TICK, 3'd0, 29'd0, 4'd0, 8'd0, now);
    endfunction

    function automatic t_step write_step(input t_cfg_idx idx, input logic [31:0] val);
        t_step s;
        s = '{reg_idx: CFG_WATCHED_BUS, default: '0};
        s.is_write = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    function automatic t_step pin(input t_step s, input t_out want);
        t_step p;
        p = s;
        p.pinned = 1'b1;
        p.want = want;
        return p;
    endfunction

    task automatic run_segment(input logic [2:0] bus, input logic [28:0] id,
                               input logic [31:0] ivl, input int count);
        t_in         d;
        logic [63:0] base;
        logic [31:0] step_max;
        logic [3:0]  ctr;
        int          pick, n;
        settle();
        write_reg(CFG_WATCHED_BUS, {29'd0, bus});
        write_reg(CFG_WATCHED_ID, {3'd0, id});
        write_reg(CFG_INTERVAL, ivl);
        i_cfg_valid <= 1'b0;
        // A tick at the top of the time range always reports, which pulls the deadline
        // down so that the new time base below is reached at once.
        d = '0;
        d.operation = OP_TICK;
        d.now_us = '1;
        send_item(d, n);
        base = {$urandom, $urandom};
        step_max = ivl / 32'd6 + 32'd1;
        ctr = 4'($urandom);
        for (int i = 0; i < count; i++) begin
            base += {32'd0, $urandom_range(0, step_max)};
            d.operation = OP_FRAME;
            d.bus_number = bus;
            d.frame_identifier = id;
            d.data_length = 4'($urandom_range(2, 15));
            d.second_data_byte = 8'($urandom);
            d.now_us = base;
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) ctr = ctr + 4'd1;
                else if (pick >= 72) ctr = 4'($urandom);
                if ($urandom_range(0, 99) < 8) begin
                    d.data_length = 4'($urandom_range(0, 1));
                    ctr = 4'd0;
                end else begin
                    d.second_data_byte[3:0] = ctr;
                end
            end else if (pick < 80) begin
                d.operation = OP_TICK;
                if ($urandom_range(0, 1) == 0) d.bus_number = 3'($urandom);
            end else if (pick < 92) begin
                if ($urandom_range(0, 1) == 0) begin
                    d.bus_number = 3'($urandom);
                    d.frame_identifier = 29'($urandom);
                end else begin
                    d.bus_number = bus ^ 3'($urandom_range(1, 7));
                end
            end else begin
                d.operation = 1'($urandom);
                d.bus_number = 3'($urandom);
                d.frame_identifier = 29'($urandom);
                d.data_length = 4'($urandom);
                d.now_us = base - {32'd0, $urandom};
            end
            send_item(d, n);
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (events_due.size() == 0) begin
                note_mismatch($sformatf("result of kind %0d with nothing outstanding",
                                        o_out_data.result_kind));
            end else begin
                want = events_due.pop_front();
                compare_field("result_kind", 64'(o_out_data.result_kind),
                              64'(want.result_kind));
                compare_field("counter_value", 64'(o_out_data.counter_value),
                              64'(want.counter_value));
                compare_field("previous_counter", 64'(o_out_data.previous_counter),
                              64'(want.previous_counter));
                compare_field("skipped_values", 64'(o_out_data.skipped_values),
                              64'(want.skipped_values));
                compare_field("gap_us", 64'(o_out_data.gap_us), 64'(want.gap_us));
                compare_field("report_received", o_out_data.report_received,
                              want.report_received);
                compare_field("report_jumps", o_out_data.report_jumps, want.report_jumps);
                compare_field("report_missed", o_out_data.report_missed, want.report_missed);
                compare_field("report_loss", 64'(o_out_data.report_loss_millipercent),
                              64'(want.report_loss_millipercent));
                compare_field("last_of_run", 64'(o_out_data.last_of_run),
                              64'(want.last_of_run));
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_out first_frame, empty_window;
        int   n;
        first_frame = '{result_kind: KIND_FIRST, counter_value: 4'd3, last_of_run: 1'b1,
                        default: '0};
        empty_window = '{result_kind: KIND_WINDOW, default: '0};
        snd_idle_pct = 13;
        rcv_idle_pct = 85;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        plan.push_back(tick_step(64'd1000));
        plan.push_back(pin(frame_step(OP_FRAME, 3'd1, 29'h249, 4'd8, 8'hA3, 64'd2000),
                           first_frame));
        plan.push_back(frame_step(OP_FRAME, 3'd1, 29'h249, 4'd8, 8'h04, 64'd2100));
        plan.push_back(frame_step(OP_FRAME, 3'd1, 29'h249, 4'd8, 8'h54, 64'd2200));
        plan.push_back(frame_step(OP_FRAME, 3'd1, 29'h249, 4'd8, 8'h09, 64'd2300));
        plan.push_back(frame_step(OP_FRAME, 3'd1, 29'h249, 4'd8, 8'hFF, 64'd2400));
        plan.push_back(frame_step(OP_FRAME, 3'd1, 29'h249, 4'd2, 8'h00, 64'd2500));
        plan.push_back(frame_step(OP_FRAME, 3'd1, 29'h249, 4'd1, 8'hFF, 64'd2600));
        plan.push_back(frame_step(OP_FRAME, 3'd1, 29'h249, 4'd0, 8'h0F, 64'd2700));
        plan.push_back(frame_step(OP_FRAME, 3'd1, 29'h249, 4'd15, 8'h0F, 64'd2800));
        plan.push_back(frame_step(OP_FRAME, 3'd0, 29'h249, 4'd8, 8'h00, 64'd2900));
        plan.push_back(frame_step(OP_FRAME, 3'd1, 29'h248, 4'd8, 8'h00, 64'd3000));
        plan.push_back(frame_step(OP_TICK, 3'd1, 29'h249, 4'd8, 8'h01, 64'd3100));
        plan.push_back(frame_step(OP_FRAME, 3'd1, 29'h249, 4'd8, 8'h00, 64'd5001000));
        plan.push_back(tick_step(64'd10000999));
        plan.push_back(pin(tick_step(64'd10001000), empty_window));
        plan.push_back(frame_step(OP_FRAME, 3'd1, 29'h249, 4'd8, 8'h01, 64'd500));
        plan.push_back(frame_step(OP_FRAME, 3'd7, 29'h1FFFFFFF, 4'd15, 8'hFF, '1));
        plan.push_back(tick_step(64'd5000000));
        plan.push_back(write_step(CFG_INTERVAL, 32'd0));
        plan.push_back(tick_step(64'd20000000));
        plan.push_back(frame_step(OP_FRAME, 3'd1, 29'h249, 4'd8, 8'h02, 64'd20000000));
        plan.push_back(write_step(CFG_WATCHED_BUS, 32'd7));
        plan.push_back(write_step(CFG_WATCHED_ID, 32'h1FFFFFFF));
        plan.push_back(write_step(CFG_INTERVAL, 32'hFFFFFFFF));
        plan.push_back(frame_step(OP_FRAME, 3'd7, 29'h1FFFFFFF, 4'd15, 8'hFF, 64'd20000001));
        plan.push_back(frame_step(OP_FRAME, 3'd1, 29'h249, 4'd8, 8'h00, 64'd20000002));
        plan.push_back(write_step(CFG_WATCHED_BUS, 32'd0));
        plan.push_back(write_step(CFG_WATCHED_ID, 32'd0));
        plan.push_back(frame_step(OP_FRAME, 3'd0, 29'd0, 4'd2, 8'h00, 64'd0));
        plan.push_back(tick_step(64'hFFFF_FFFF_0000_0000));

        foreach (plan[k]) begin
            if (plan[k].is_write) begin
                settle();
                write_reg(plan[k].reg_idx, plan[k].reg_val);
                i_cfg_valid <= 1'b0;
            end else begin
                send_item(plan[k].item, n);
                if (plan[k].pinned && n > 0) begin
                    events_due[events_due.size() - n] = plan[k].want;
                end
            end
        end

        run_segment(WATCHED_BUS_RST, WATCHED_ID_RST, 32'd20000, 53);
        run_segment(3'd0, 29'd0, 32'd1, 53);
        snd_idle_pct = 85;
        rcv_idle_pct = 13;
        run_segment(3'd7, 29'h1FFFFFFF, 32'hFFFFFFFF, 53);
        run_segment(3'($urandom), 29'($urandom), $urandom_range(1000, 100000), 53);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_segment(3'($urandom), 29'($urandom), $urandom, 53);
        run_segment(WATCHED_BUS_RST, WATCHED_ID_RST, INTERVAL_RST, 53);
        settle();

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

### rolling_counter_loss_monitor_top.f
rtl/core/rclm_pkg.sv
rtl/core/rclm_div.sv
rtl/core/rclm_datapath.sv
rtl/core/rclm_ctrl.sv
rtl/core/rolling_counter_loss_monitor_top.sv
verif/tb.sv
